FILE: design/mma_pkg.sv
package mma_pkg;

  // Message length codes; LEN_NONE marks bytes that start no message
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // Status high nibbles
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_PROG_CHG  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;

  // System status bytes with a length other than one
  localparam logic [7:0] SYS_EXCL     = 8'hF0;
  localparam logic [7:0] SYS_MTC_QF   = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
  localparam logic [7:0] SYS_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] SYS_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] SYS_EOX      = 8'hF7;

  typedef struct packed {
    logic [1:0] msg_length;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } msg_t;

  function automatic logic [1:0] msg_len_of(input logic [7:0] b);
    logic [1:0] len;
    if (!b[7]) begin
      len = LEN_NONE;
    end else if (b[7:4] != HI_SYSTEM) begin
      len = (b[7:4] == HI_PROG_CHG || b[7:4] == HI_CHAN_PRES) ? LEN_TWO : LEN_THREE;
    end else begin
      unique case (b)
        SYS_MTC_QF, SYS_SONG_SEL:                     len = LEN_TWO;
        SYS_SONG_POS:                                 len = LEN_THREE;
        SYS_EXCL, SYS_UNDEF_F4, SYS_UNDEF_F5, SYS_EOX: len = LEN_NONE;
        default:                                      len = LEN_ONE;
      endcase
    end
    return len;
  endfunction

  function automatic logic is_note(input logic [7:0] b);
    return (b[7:4] == HI_NOTE_OFF) || (b[7:4] == HI_NOTE_ON);
  endfunction

endpackage

FILE: design/midi_ifs.sv
interface midi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface midi_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_length;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;

  modport source (output valid, output msg_length, output status_byte,
                  output first_data, output second_data, input ready);
  modport sink (input valid, input msg_length, input status_byte,
                input first_data, input second_data, output ready);
endinterface

FILE: design/mma_out_buf.sv
module mma_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mma_pkg::msg_t push_msg,
  output logic          full,
  midi_msg_if.source    msg_out
);
  import mma_pkg::*;

  msg_t main_msg;
  msg_t skid_msg;
  logic main_valid;
  logic skid_valid;
  logic pop;

  assign pop  = main_valid && msg_out.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no push possible while the skid entry is occupied
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_msg <= skid_msg;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_msg <= push_msg;
      end else begin
        skid_msg <= push_msg;
      end
    end
  end

  assign msg_out.valid       = main_valid;
  assign msg_out.msg_length  = main_msg.msg_length;
  assign msg_out.status_byte = main_msg.status_byte;
  assign msg_out.first_data  = main_msg.first_data;
  assign msg_out.second_data = main_msg.second_data;

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full output buffer");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (main_valid && !msg_out.ready) |=> (main_valid && $stable(main_msg)))
    else $error("output message changed while receiver stalled");
`endif

endmodule

FILE: design/midi_message_assembler.sv
// MIDI message assembler.
// byte_in (sink): one received MIDI byte per transfer, status or data.
// msg_out (source): one complete message per transfer; msg_length gives the
//   number of valid bytes (1..3), unused data bytes read as zero.
// Running status applies only after a completed note-on or note-off; any
// status byte clears it. A status byte during a message aborts it silently.
// Sysex, EOX and the undefined bytes F4 and F5 are dropped.
// Throughput: one byte per cycle while byte_in ready is high. On the transfer
// of its last byte (one-byte messages: the status byte) a message is
// registered into the output register, or into the skid entry if it is busy.
// Results sit in an output register backed by one skid entry, so byte_in
// stays ready while a finished message waits. If the receiver stalls and
// both entries fill, byte_in ready drops until the receiver takes one.
// Reset (synchronous, active high) clears the parser state, running status
// and both output entries.
module midi_message_assembler (
  input  logic       clk,
  input  logic       rst,
  midi_byte_if.sink  byte_in,
  midi_msg_if.source msg_out
);
  import mma_pkg::*;

  logic       reading;
  logic       running;
  logic [1:0] fill_pos;
  logic [7:0] status_reg;
  logic [7:0] data1;
  logic [7:0] data2;

  logic       reading_next;
  logic       running_next;
  logic [1:0] fill_pos_next;
  logic [7:0] status_reg_next;
  logic [7:0] data1_next;
  logic [7:0] data2_next;

  logic       accept;
  logic       buf_full;
  logic       is_status;
  logic [1:0] new_len;
  logic [1:0] cur_len;
  logic [1:0] pos_inc;
  logic       emit;
  msg_t       result;

  assign byte_in.ready = !buf_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign is_status     = byte_in.rx_byte[7];
  assign new_len       = msg_len_of(byte_in.rx_byte);
  assign cur_len       = msg_len_of(status_reg);
  assign pos_inc       = fill_pos + 2'd1;

  always_comb begin
    reading_next    = reading;
    running_next    = running;
    fill_pos_next   = fill_pos;
    status_reg_next = status_reg;
    data1_next      = data1;
    data2_next      = data2;
    emit            = 1'b0;
    result          = '0;
    if (accept) begin
      if (reading) begin
        if (is_status) begin
          reading_next = 1'b0;
          running_next = 1'b0;
        end else begin
          // fill position is 1 or 2 while reading
          if (fill_pos == LEN_ONE) begin
            data1_next = byte_in.rx_byte;
          end else begin
            data2_next = byte_in.rx_byte;
          end
          fill_pos_next = pos_inc;
          if (pos_inc >= cur_len) begin
            reading_next       = 1'b0;
            running_next       = is_note(status_reg);
            emit               = 1'b1;
            result.msg_length  = pos_inc;
            result.status_byte = status_reg;
            result.first_data  = data1_next;
            result.second_data = (pos_inc == LEN_THREE) ? data2_next : 8'd0;
          end
        end
      end else if (is_status) begin
        running_next = 1'b0;
        if (new_len != LEN_NONE) begin
          status_reg_next = byte_in.rx_byte;
          if (new_len == LEN_ONE) begin
            emit               = 1'b1;
            result.msg_length  = LEN_ONE;
            result.status_byte = byte_in.rx_byte;
          end else begin
            fill_pos_next = LEN_ONE;
            reading_next  = 1'b1;
          end
        end
      end else if (running) begin
        // running status: data byte is the first data after the stored note status
        data1_next    = byte_in.rx_byte;
        fill_pos_next = LEN_TWO;
        reading_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading    <= 1'b0;
      running    <= 1'b0;
      fill_pos   <= LEN_NONE;
      status_reg <= 8'd0;
      data1      <= 8'd0;
      data2      <= 8'd0;
    end else begin
      reading    <= reading_next;
      running    <= running_next;
      fill_pos   <= fill_pos_next;
      status_reg <= status_reg_next;
      data1      <= data1_next;
      data2      <= data2_next;
    end
  end

  mma_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (emit),
    .push_msg (result),
    .full     (buf_full),
    .msg_out  (msg_out)
  );

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    reading |-> (fill_pos == LEN_ONE || fill_pos == LEN_TWO))
    else $error("fill position out of range while reading");

  a_running_is_note: assert property (@(posedge clk) disable iff (rst)
    running |-> is_note(status_reg))
    else $error("running status held without note status");

  a_status_aborts: assert property (@(posedge clk) disable iff (rst)
    (accept && reading && is_status) |=> (!reading && !running))
    else $error("status byte did not abort message");
`endif

endmodule
